// ===== sv/g2hfe_pkg.sv =====
// shared types and constants for the grib2 header field extractor
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package g2hfe_pkg;

  localparam int IndicatorBytes  = 16;
  localparam int SecHdrBytes     = 5;
  localparam int PosWidth        = 32;
  localparam int SkipWidth       = 10;
  localparam int PaddrWidth      = 3;
  localparam int ApbDataWidth    = 32;
  localparam int QueueDepthDflt  = 2;

  // register index, taken from paddr word bit
  localparam logic RegIdxHeaderSkip = 1'b0;

  localparam logic [7:0] SecIdentification = 8'd1;
  localparam logic [7:0] SecProduct        = 8'd4;
  localparam logic [7:0] EditionTwo        = 8'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_ED2    = 3'd1,
    ST_NO_MARKER  = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_BAD_LENGTH = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    SLOT_NONE,
    SLOT_EDITION,
    SLOT_CENTER_HI,
    SLOT_CENTER_LO,
    SLOT_SUBC_HI,
    SLOT_SUBC_LO,
    SLOT_YEAR_HI,
    SLOT_YEAR_LO,
    SLOT_MONTH,
    SLOT_DAY,
    SLOT_HOUR,
    SLOT_MINUTE,
    SLOT_MODEL,
    SLOT_TIME_UNIT,
    SLOT_FT_B3,
    SLOT_FT_B2,
    SLOT_FT_B1,
    SLOT_FT_B0
  } slot_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  edition;
    logic [15:0] center;
    logic [15:0] subcenter;
    logic [7:0]  model;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  time_unit;
    logic [31:0] forecast_time;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  edition;
    logic [15:0] center;
    logic [15:0] subcenter;
    logic [7:0]  model;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  time_unit;
    logic [31:0] forecast_time;
  } capture_t;

  // one classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    slot_e      slot;
    logic       emit;
    status_e    status;
    logic       clear;
  } op_t;

endpackage

// ===== sv/g2hfe_front.sv =====
// front end: accepts stream bytes, runs the section walk and classifies each byte
// into a capture slot and record command; uses g2hfe_pkg
`timescale 1ns / 1ps

module g2hfe_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [g2hfe_pkg::SkipWidth-1:0]     skip_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  g2hfe_pkg::in_item_t                 in_data_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output g2hfe_pkg::op_t                      op_o
);

  localparam int PosW = g2hfe_pkg::PosWidth;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_INDIC,
    PH_SECHDR,
    PH_SECBODY,
    PH_DISCARD
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   len_q, len_d;
  logic [7:0]        num_q, num_d;
  logic              mbad_q, mbad_d;
  logic              ed2_q, ed2_d;
  logic              accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  function automatic logic [7:0] marker_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h47;
      2'd1:    m = 8'h52;
      2'd2:    m = 8'h49;
      default: m = 8'h42;
    endcase
    return m;
  endfunction

  function automatic g2hfe_pkg::slot_e body_slot(input logic [7:0] num,
                                                 input logic [PosW-1:0] pos);
    g2hfe_pkg::slot_e s;
    s = g2hfe_pkg::SLOT_NONE;
    if (pos[PosW-1:5] == '0) begin
      if (num == g2hfe_pkg::SecIdentification) begin
        case (pos[4:0])
          5'd5:    s = g2hfe_pkg::SLOT_CENTER_HI;
          5'd6:    s = g2hfe_pkg::SLOT_CENTER_LO;
          5'd7:    s = g2hfe_pkg::SLOT_SUBC_HI;
          5'd8:    s = g2hfe_pkg::SLOT_SUBC_LO;
          5'd12:   s = g2hfe_pkg::SLOT_YEAR_HI;
          5'd13:   s = g2hfe_pkg::SLOT_YEAR_LO;
          5'd14:   s = g2hfe_pkg::SLOT_MONTH;
          5'd15:   s = g2hfe_pkg::SLOT_DAY;
          5'd16:   s = g2hfe_pkg::SLOT_HOUR;
          5'd17:   s = g2hfe_pkg::SLOT_MINUTE;
          default: s = g2hfe_pkg::SLOT_NONE;
        endcase
      end else if (num == g2hfe_pkg::SecProduct) begin
        case (pos[4:0])
          5'd13:   s = g2hfe_pkg::SLOT_MODEL;
          5'd17:   s = g2hfe_pkg::SLOT_TIME_UNIT;
          5'd18:   s = g2hfe_pkg::SLOT_FT_B3;
          5'd19:   s = g2hfe_pkg::SLOT_FT_B2;
          5'd20:   s = g2hfe_pkg::SLOT_FT_B1;
          5'd21:   s = g2hfe_pkg::SLOT_FT_B0;
          default: s = g2hfe_pkg::SLOT_NONE;
        endcase
      end
    end
    return s;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       sec_end;
    b       = in_data_i.data_byte;
    sec_end = 1'b0;
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    num_d   = num_q;
    mbad_d  = mbad_q;
    ed2_d   = ed2_q;
    op_o.data   = b;
    op_o.slot   = g2hfe_pkg::SLOT_NONE;
    op_o.emit   = 1'b0;
    op_o.status = g2hfe_pkg::ST_OK;
    op_o.clear  = 1'b0;

    if (phase_d == PH_SKIP) begin
      if (pos_d >= PosW'(skip_i)) begin
        phase_d = PH_INDIC;
        pos_d   = '0;
      end else begin
        pos_d = pos_d + 1'b1;
      end
    end

    case (phase_d)
      PH_INDIC: begin
        if (pos_d < PosW'(4)) begin
          if (b != marker_byte(pos_d[1:0])) mbad_d = 1'b1;
        end else if (pos_d == PosW'(7)) begin
          op_o.slot = g2hfe_pkg::SLOT_EDITION;
          ed2_d     = (b == g2hfe_pkg::EditionTwo);
        end
        if (pos_d >= PosW'(g2hfe_pkg::IndicatorBytes - 1)) begin
          if (mbad_d) begin
            op_o.emit   = 1'b1;
            op_o.status = g2hfe_pkg::ST_NO_MARKER;
            phase_d     = PH_DISCARD;
          end else if (!ed2_d) begin
            op_o.emit   = 1'b1;
            op_o.status = g2hfe_pkg::ST_NOT_ED2;
            phase_d     = PH_DISCARD;
          end else begin
            phase_d = PH_SECHDR;
            pos_d   = '0;
          end
        end else begin
          pos_d = pos_d + 1'b1;
        end
      end
      PH_SECHDR: begin
        if (pos_d < PosW'(4)) begin
          len_d = {((pos_d == '0) ? 24'd0 : len_d[PosW-9:0]), b};
          pos_d = pos_d + 1'b1;
        end else begin
          num_d = b;
          if (len_d < PosW'(g2hfe_pkg::SecHdrBytes)) begin
            op_o.emit   = 1'b1;
            op_o.status = g2hfe_pkg::ST_BAD_LENGTH;
            phase_d     = PH_DISCARD;
          end else if (len_d == PosW'(g2hfe_pkg::SecHdrBytes)) begin
            sec_end = 1'b1;
          end else begin
            phase_d = PH_SECBODY;
            pos_d   = PosW'(g2hfe_pkg::SecHdrBytes);
          end
        end
      end
      PH_SECBODY: begin
        op_o.slot = body_slot(num_d, pos_d);
        if (pos_d >= len_d - 1'b1) sec_end = 1'b1;
        else pos_d = pos_d + 1'b1;
      end
      default: ;
    endcase

    if (sec_end) begin
      if (num_d == g2hfe_pkg::SecProduct) begin
        op_o.emit   = 1'b1;
        op_o.status = g2hfe_pkg::ST_OK;
        phase_d     = PH_DISCARD;
      end else begin
        phase_d = PH_SECHDR;
        pos_d   = '0;
      end
    end

    // end of stream closes the message, truncated unless a record already went out
    if (in_data_i.end_of_stream) begin
      if (!op_o.emit && phase_d != PH_DISCARD) begin
        op_o.emit   = 1'b1;
        op_o.status = g2hfe_pkg::ST_TRUNCATED;
      end
      op_o.clear = 1'b1;
      phase_d    = PH_SKIP;
      pos_d      = '0;
      len_d      = '0;
      num_d      = '0;
      mbad_d     = 1'b0;
      ed2_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      pos_q   <= '0;
      len_q   <= '0;
      num_q   <= '0;
      mbad_q  <= 1'b0;
      ed2_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      num_q   <= num_d;
      mbad_q  <= mbad_d;
      ed2_q   <= ed2_d;
    end
  end

endmodule

// ===== sv/g2hfe_queue.sv =====
// small fifo of classified bytes between the front and back ends
// uses g2hfe_pkg for the entry type
`timescale 1ns / 1ps

module g2hfe_queue #(
  parameter int Depth = g2hfe_pkg::QueueDepthDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  g2hfe_pkg::op_t   push_data_i,
  input  logic             pop_i,
  output g2hfe_pkg::op_t   head_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  g2hfe_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== sv/g2hfe_back.sv =====
// back end: applies captures from the queue and drives the registered record output
// uses g2hfe_pkg for entry, capture and record types
`timescale 1ns / 1ps

module g2hfe_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  g2hfe_pkg::op_t         head_i,
  input  logic                   head_valid_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output g2hfe_pkg::out_item_t   out_data_o
);

  g2hfe_pkg::capture_t  cap_q, cap_next;
  g2hfe_pkg::out_item_t out_data_q;
  logic                 out_valid_q;
  logic                 out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = head_valid_i && (!head_i.emit || out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    cap_next = cap_q;
    case (head_i.slot)
      g2hfe_pkg::SLOT_EDITION:   cap_next.edition             = head_i.data;
      g2hfe_pkg::SLOT_CENTER_HI: cap_next.center[15:8]        = head_i.data;
      g2hfe_pkg::SLOT_CENTER_LO: cap_next.center[7:0]         = head_i.data;
      g2hfe_pkg::SLOT_SUBC_HI:   cap_next.subcenter[15:8]     = head_i.data;
      g2hfe_pkg::SLOT_SUBC_LO:   cap_next.subcenter[7:0]      = head_i.data;
      g2hfe_pkg::SLOT_YEAR_HI:   cap_next.year[15:8]          = head_i.data;
      g2hfe_pkg::SLOT_YEAR_LO:   cap_next.year[7:0]           = head_i.data;
      g2hfe_pkg::SLOT_MONTH:     cap_next.month               = head_i.data;
      g2hfe_pkg::SLOT_DAY:       cap_next.day                 = head_i.data;
      g2hfe_pkg::SLOT_HOUR:      cap_next.hour                = head_i.data;
      g2hfe_pkg::SLOT_MINUTE:    cap_next.minute              = head_i.data;
      g2hfe_pkg::SLOT_MODEL:     cap_next.model               = head_i.data;
      g2hfe_pkg::SLOT_TIME_UNIT: cap_next.time_unit           = head_i.data;
      g2hfe_pkg::SLOT_FT_B3:     cap_next.forecast_time[31:24] = head_i.data;
      g2hfe_pkg::SLOT_FT_B2:     cap_next.forecast_time[23:16] = head_i.data;
      g2hfe_pkg::SLOT_FT_B1:     cap_next.forecast_time[15:8]  = head_i.data;
      g2hfe_pkg::SLOT_FT_B0:     cap_next.forecast_time[7:0]   = head_i.data;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // capture lands before the record is built, clear after it
      if (pop_o) cap_q <= head_i.clear ? '0 : cap_next;
      if (pop_o && head_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.emit) begin
      out_data_q <= {cap_next, head_i.status};
    end
  end

endmodule

// ===== sv/grib2_header_field_extractor.sv =====
// Byte-stream GRIB2 header parser. One byte is taken per cycle with no gaps of its own;
// the only thing that slows input is a stalled result output, and then the byte queue
// between the front end and the record stage (QueueDepth entries) fills before
// in_stall_o rises. A record built from the byte that completes it passes through the
// queue and then the output register before it leaves on out_data_o. Each message yields
// exactly one record (ok, not edition 2, no marker, truncated or bad section length),
// and bytes after it are dropped up to end_of_stream. header_skip_bytes is written over
// the APB port at byte address 0; no clearing pass follows reset.
// top level: instantiates g2hfe_front, g2hfe_queue and g2hfe_back; uses g2hfe_pkg
`timescale 1ns / 1ps

module grib2_header_field_extractor #(
  parameter int QueueDepth = g2hfe_pkg::QueueDepthDflt
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [g2hfe_pkg::PaddrWidth-1:0]       paddr,
  input  logic [g2hfe_pkg::ApbDataWidth-1:0]     pwdata,
  output logic [g2hfe_pkg::ApbDataWidth-1:0]     prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  g2hfe_pkg::in_item_t                    in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output g2hfe_pkg::out_item_t                   out_data_o
);

  logic [g2hfe_pkg::SkipWidth-1:0] skip_q;
  logic                            cfg_wr;
  logic                            q_full, q_empty, push, pop;
  g2hfe_pkg::op_t                  push_op, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == g2hfe_pkg::RegIdxHeaderSkip);
  assign prdata = (paddr[2] == g2hfe_pkg::RegIdxHeaderSkip) ?
                  g2hfe_pkg::ApbDataWidth'(skip_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
    end else if (cfg_wr) begin
      skip_q <= pwdata[g2hfe_pkg::SkipWidth-1:0];
    end
  end

  g2hfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .skip_i     (skip_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  g2hfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  g2hfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTH
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue reports full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.emit) |-> (!out_valid_o || !out_stall_i))
    else $error("record issued while output holds a stalled item");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("front end pushed into a full queue");
`endif

endmodule

// ===== tb/tb_grib2_header_field_extractor.sv =====
// self-checking bench for grib2_header_field_extractor: byte stream in, header records out
// a clocked driver and monitor around a predictor of the parser; depends on g2hfe_pkg
`timescale 1ns / 1ps

module tb_grib2_header_field_extractor;

  localparam int PaddrW = g2hfe_pkg::PaddrWidth;
  localparam int ApbW   = g2hfe_pkg::ApbDataWidth;
  localparam int SkipW  = g2hfe_pkg::SkipWidth;

  localparam logic [31:0] GribTag = "GRIB";
  localparam logic [PaddrW-1:0] SkipRegAddr = PaddrW'({g2hfe_pkg::RegIdxHeaderSkip, 2'b00});

  typedef enum logic [2:0] {
    WALK_SKIP,
    WALK_INDICATOR,
    WALK_SEC_HEAD,
    WALK_SEC_BODY,
    WALK_DISCARD
  } walk_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [ApbW-1:0] pwdata = '0;
  logic [ApbW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  g2hfe_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  g2hfe_pkg::out_item_t out_data_o;

  grib2_header_field_extractor dut (.*);

  always #4 clk_i = ~clk_i;

  // parser state as the block should hold it
  walk_e walk = WALK_SKIP;
  logic [SkipW-1:0] skip_cfg = '0;
  logic [31:0] walk_pos = '0;
  logic [31:0] sec_len = '0;
  logic [7:0] sec_num = '0;
  logic marker_bad = 1'b0;
  g2hfe_pkg::capture_t fields = '0;
  g2hfe_pkg::out_item_t records_due[$];

  g2hfe_pkg::in_item_t byte_feed[$];
  logic [7:0] msg[$];
  int unsigned fed_bytes = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;

  function automatic void post_record(g2hfe_pkg::status_e st);
    records_due.push_back(g2hfe_pkg::out_item_t'({fields, st}));
  endfunction

  function automatic logic close_section();
    if (sec_num == g2hfe_pkg::SecProduct) begin
      post_record(g2hfe_pkg::ST_OK);
      walk = WALK_DISCARD;
      return 1'b1;
    end
    walk = WALK_SEC_HEAD;
    walk_pos = '0;
    return 1'b0;
  endfunction

  function automatic void grab(logic [31:0] pos, logic [7:0] b);
    if (sec_num == g2hfe_pkg::SecIdentification) begin
      case (pos)
        5: fields.center[15:8] = b;
        6: fields.center[7:0] = b;
        7: fields.subcenter[15:8] = b;
        8: fields.subcenter[7:0] = b;
        12: fields.year[15:8] = b;
        13: fields.year[7:0] = b;
        14: fields.month = b;
        15: fields.day = b;
        16: fields.hour = b;
        17: fields.minute = b;
        default: ;
      endcase
    end else if (sec_num == g2hfe_pkg::SecProduct) begin
      case (pos)
        13: fields.model = b;
        17: fields.time_unit = b;
        18: fields.forecast_time[31:24] = b;
        19: fields.forecast_time[23:16] = b;
        20: fields.forecast_time[15:8] = b;
        21: fields.forecast_time[7:0] = b;
        default: ;
      endcase
    end
  endfunction

  function automatic void parse_byte(g2hfe_pkg::in_item_t it);
    logic [7:0] b;
    logic done;
    b = it.data_byte;
    done = 1'b0;
    if (walk == WALK_SKIP) begin
      if (walk_pos >= 32'(skip_cfg)) begin
        walk = WALK_INDICATOR;
        walk_pos = '0;
      end else begin
        walk_pos++;
      end
    end
    case (walk)
      WALK_INDICATOR: begin
        if (walk_pos < 4) begin
          if (b != GribTag[31 - 8 * walk_pos[1:0] -: 8]) marker_bad = 1'b1;
        end else if (walk_pos == 7) begin
          fields.edition = b;
        end
        if (walk_pos >= g2hfe_pkg::IndicatorBytes - 1) begin
          if (marker_bad) begin
            post_record(g2hfe_pkg::ST_NO_MARKER);
            done = 1'b1;
            walk = WALK_DISCARD;
          end else if (fields.edition != g2hfe_pkg::EditionTwo) begin
            post_record(g2hfe_pkg::ST_NOT_ED2);
            done = 1'b1;
            walk = WALK_DISCARD;
          end else begin
            walk = WALK_SEC_HEAD;
            walk_pos = '0;
          end
        end else begin
          walk_pos++;
        end
      end
      WALK_SEC_HEAD: begin
        if (walk_pos < 4) begin
          sec_len = (walk_pos == 0) ? {24'd0, b} : {sec_len[23:0], b};
          walk_pos++;
        end else begin
          sec_num = b;
          if (sec_len < g2hfe_pkg::SecHdrBytes) begin
            post_record(g2hfe_pkg::ST_BAD_LENGTH);
            done = 1'b1;
            walk = WALK_DISCARD;
          end else if (sec_len == g2hfe_pkg::SecHdrBytes) begin
            done = close_section();
          end else begin
            walk = WALK_SEC_BODY;
            walk_pos = g2hfe_pkg::SecHdrBytes;
          end
        end
      end
      WALK_SEC_BODY: begin
        grab(walk_pos, b);
        if (walk_pos >= sec_len - 1) done = close_section();
        else walk_pos++;
      end
      default: ;
    endcase
    if (it.end_of_stream) begin
      if (!done && walk != WALK_DISCARD) post_record(g2hfe_pkg::ST_TRUNCATED);
      walk = WALK_SKIP;
      walk_pos = '0;
      sec_len = '0;
      sec_num = '0;
      marker_bad = 1'b0;
      fields = '0;
    end
  endfunction

  // mostly no pause, some short ones, a few long
  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) parse_byte(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (byte_feed.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= byte_feed.pop_front();
          if ($urandom_range(0, 199) == 0) send_quiet = !send_quiet;
          send_gap = idle_len(send_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_record(g2hfe_pkg::out_item_t want, g2hfe_pkg::out_item_t got);
    check_field("edition", want.edition, got.edition);
    check_field("center", want.center, got.center);
    check_field("subcenter", want.subcenter, got.subcenter);
    check_field("model", want.model, got.model);
    check_field("year", want.year, got.year);
    check_field("month", want.month, got.month);
    check_field("day", want.day, got.day);
    check_field("hour", want.hour, got.hour);
    check_field("minute", want.minute, got.minute);
    check_field("time_unit", want.time_unit, got.time_unit);
    check_field("forecast_time", want.forecast_time, got.forecast_time);
    check_field("status", want.status, got.status);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (records_due.size() == 0) begin
          $error("record item with no expected record pending");
          mismatches++;
        end else begin
          check_record(records_due.pop_front(), out_data_o);
        end
      end
      // one long hold-off so the byte queue backs up into the sender
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_stall_i <= 1'b1;
        hold_left = 600;
      end else if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        if ($urandom_range(0, 199) == 0) recv_quiet = !recv_quiet;
        hold_left = idle_len(recv_quiet);
        out_stall_i <= (hold_left != 0);
        if (hold_left != 0) hold_left--;
      end
    end
  end

  task automatic put_bytes(int n, int fill);
    repeat (n) msg.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  // bad_pos below zero keeps the marker intact
  task automatic put_indicator(int bad_pos, logic [7:0] ed);
    logic [7:0] b;
    for (int i = 0; i < g2hfe_pkg::IndicatorBytes; i++) begin
      if (i < 4) begin
        b = GribTag[31 - 8 * i -: 8];
        if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      end else if (i == 7) begin
        b = ed;
      end else begin
        b = 8'($urandom);
      end
      msg.push_back(b);
    end
  endtask

  task automatic put_section(logic [31:0] len, logic [7:0] num, int body, int fill);
    for (int i = 3; i >= 0; i--) msg.push_back(len[8 * i +: 8]);
    msg.push_back(num);
    put_bytes(body, fill);
  endtask

  task automatic put_plain_record(int fill);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(21, g2hfe_pkg::SecIdentification, 16, fill);
    put_section(34, g2hfe_pkg::SecProduct, 29, fill);
  endtask

  task automatic send_msg(bit close);
    g2hfe_pkg::in_item_t it;
    foreach (msg[i]) begin
      it.data_byte = msg[i];
      it.end_of_stream = close && (i == msg.size() - 1);
      byte_feed.push_back(it);
    end
    fed_bytes += msg.size();
    msg.delete();
  endtask

  task automatic random_message(int skip);
    int kind;
    int len;
    int cut;
    logic [7:0] num;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      put_bytes($urandom_range(1, 40), -1);
    end else begin
      put_bytes(skip, -1);
      if (kind < 16) begin
        put_indicator($urandom_range(0, 3), 8'($urandom));
      end else if (kind < 24) begin
        put_indicator(-1, g2hfe_pkg::EditionTwo ^ 8'($urandom_range(1, 255)));
      end else begin
        put_indicator(-1, g2hfe_pkg::EditionTwo);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 2) == 0) begin
            num = 8'($urandom);
            if (num == g2hfe_pkg::SecProduct) num = 8'd3;
          end else begin
            num = g2hfe_pkg::SecIdentification;
          end
          len = ($urandom_range(0, 1) != 0) ? 21 : $urandom_range(5, 24);
          put_section(len, num, len - 5, -1);
        end
        if (kind < 32) put_section($urandom_range(0, 4), 8'($urandom), 0, -1);
        len = ($urandom_range(0, 2) != 0) ? 34 : $urandom_range(5, 40);
        put_section(len, g2hfe_pkg::SecProduct, len - 5, -1);
      end
      put_bytes($urandom_range(0, 6), -1);
    end
    if (kind >= 88 && msg.size() > 1) begin
      cut = $urandom_range(1, msg.size() - 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end
    send_msg(1'b1);
  endtask

  task automatic set_skip(logic [SkipW-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SkipRegAddr;
    pwdata <= ApbW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    skip_cfg = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[SkipW-1:0] !== v) begin
      $error("header_skip_bytes readback mismatch: expected 0x%0h, got 0x%0h", v, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // every byte taken, every record back, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk_i); while (byte_feed.size() != 0 || in_valid_i || records_due.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int skip;
    int unsigned r;
    bit first_phase;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_skip(SkipW'(0));
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(21, g2hfe_pkg::SecIdentification, 16, -1);
    put_section(5, 8'd2, 0, -1);
    put_section(8, 8'd3, 3, -1);
    put_section(34, g2hfe_pkg::SecProduct, 29, -1);
    put_bytes(3, -1);
    send_msg(1'b1);
    put_plain_record(8'h00);
    put_bytes(1, 8'h00);
    send_msg(1'b1);
    put_plain_record(8'hff);
    put_bytes(1, 8'hff);
    send_msg(1'b1);
    // broken marker in each position; the first one ends on indicator byte 15
    for (int p = 0; p < 4; p++) begin
      put_indicator(p, 8'($urandom));
      put_bytes(p, -1);
      send_msg(1'b1);
    end
    put_indicator(-1, 8'd1);
    put_bytes(2, -1);
    send_msg(1'b1);
    put_indicator(-1, 8'd255);
    send_msg(1'b1);
    put_indicator(-1, 8'd0);
    put_bytes(1, -1);
    send_msg(1'b1);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(0, g2hfe_pkg::SecIdentification, 0, -1);
    put_bytes(4, -1);
    send_msg(1'b1);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(21, g2hfe_pkg::SecIdentification, 16, -1);
    put_section(4, g2hfe_pkg::SecProduct, 0, -1);
    send_msg(1'b1);
    // section 4 too short to reach the forecast fields
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(21, g2hfe_pkg::SecIdentification, 16, -1);
    put_section(15, g2hfe_pkg::SecProduct, 10, -1);
    put_bytes(2, -1);
    send_msg(1'b1);
    // section 4 of bare header length, stream ends on its number byte
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(21, g2hfe_pkg::SecIdentification, 16, -1);
    put_section(5, g2hfe_pkg::SecProduct, 0, -1);
    send_msg(1'b1);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(21, g2hfe_pkg::SecIdentification, 16, -1);
    put_section(21, g2hfe_pkg::SecIdentification, 16, -1);
    put_section(34, g2hfe_pkg::SecProduct, 29, -1);
    send_msg(1'b1);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    repeat (6) void'(msg.pop_back());
    send_msg(1'b1);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_bytes(2, -1);
    send_msg(1'b1);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(21, g2hfe_pkg::SecIdentification, 16, -1);
    put_section(34, g2hfe_pkg::SecProduct, 10, -1);
    send_msg(1'b1);
    put_indicator(-1, g2hfe_pkg::EditionTwo);
    put_section(32'hffff_ff00, 8'd3, 6, -1);
    send_msg(1'b1);
    put_bytes(1, -1);
    send_msg(1'b1);
    put_plain_record(-1);
    send_msg(1'b1);
    wait_idle();

    set_skip(SkipW'(3));
    repeat (2) begin
      put_bytes(3, -1);
      put_plain_record(-1);
      send_msg(1'b1);
    end
    // stop inside the transport header, then shrink the skip count below it
    put_bytes(2, -1);
    send_msg(1'b0);
    wait_idle();
    set_skip(SkipW'(1));
    put_plain_record(-1);
    send_msg(1'b1);
    wait_idle();

    // largest skip count: the stream ends while still in the transport header
    set_skip(SkipW'(1023));
    put_bytes(40, -1);
    send_msg(1'b1);
    wait_idle();

    first_phase = 1'b1;
    while (fed_bytes < 1850) begin
      r = $urandom_range(0, 9);
      skip = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      set_skip(SkipW'(skip));
      repeat (first_phase ? 8 : $urandom_range(2, 4)) random_message(skip);
      if (first_phase) squeeze_req = 1'b1;
      first_phase = 1'b0;
      wait_idle();
    end

    repeat (16) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
